[rtl/ira_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ira_pkg - interval resource allocator types
// Request and result payloads and the sequencer state type.
// ----------------------------------------------------------------------------
package ira_pkg;

    localparam int TIME_W = 32;
    localparam int OUT_ID_W = 9;

    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
        logic              last_request;
    } ira_req_t;

    typedef struct packed {
        logic [OUT_ID_W-1:0] assigned_id;
        logic [OUT_ID_W-1:0] ids_in_use_total;
        logic                overflow;
    } ira_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ALLOC,
        ST_POP,
        ST_DONE
    } ira_state_t;

endpackage
`default_nettype wire

[rtl/ira_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ira_req_if - request channel
// Valid/ready channel carrying one interval request.
// ----------------------------------------------------------------------------
interface ira_req_if;
    import ira_pkg::*;
    logic     valid;
    logic     ready;
    ira_req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/ira_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ira_rsp_if - result channel
// Valid/ready channel carrying one allocation result.
// ----------------------------------------------------------------------------
interface ira_rsp_if;
    import ira_pkg::*;
    logic     valid;
    logic     ready;
    ira_rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/interval_resource_allocator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// interval_resource_allocator - interval partitioning id allocator
// Each request is given a resource id; ids whose intervals ended before the
// request's start are recycled through a LIFO free stack.
// ----------------------------------------------------------------------------
// One request is handled at a time. Each accepted request walks the busy
// list, then takes an id in ST_ALLOC, popping it from the free stack through
// ST_POP or drawing a fresh one, or flags overflow, and is delivered from
// ST_DONE; the walk grows with the number of busy entries. The busy list
// memory is walked one entry per cycle through its single read port,
// compacting kept entries in place and pushing expired ids on the free stack
// memory. The result sits in an output register; the block returns to idle,
// ready for the next request, as that result is loaded, and a result still
// waiting at the output holds the block until it is taken.
module interval_resource_allocator #(
    parameter int MAX_IDS = 256
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ira_req_if.sink   req,
    ira_rsp_if.source rsp
);
    import ira_pkg::*;

    localparam int CW = $clog2(MAX_IDS + 1);
    localparam int AW = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
    localparam int BW = TIME_W + CW;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_IDS);

    ira_state_t state_reg, state_next;
    logic [CW-1:0] busy_count_reg, busy_count_next;
    logic [CW-1:0] free_depth_reg, free_depth_next;
    logic [CW-1:0] created_reg, created_next;
    logic [CW-1:0] rd_reg, rd_next;
    logic [CW-1:0] wr_reg, wr_next;
    logic          pend_reg, pend_next;
    logic [CW-1:0] id_reg, id_next;
    logic          ovf_reg, ovf_next;
    ira_req_t      cur_reg, cur_next;
    logic          out_valid_reg, out_valid_next;
    ira_rsp_t      out_reg, out_next;

    logic [BW-1:0] busy_mem [MAX_IDS];
    logic [CW-1:0] free_mem [MAX_IDS];
    logic [BW-1:0] busy_rdata;
    logic [CW-1:0] free_rdata;
    logic          busy_we;
    logic [AW-1:0] busy_waddr;
    logic [BW-1:0] busy_wdata;
    logic          free_we;
    logic [AW-1:0] free_raddr;
    logic [CW-1:0] free_dec;

    logic [TIME_W-1:0] rd_end;
    logic [CW-1:0]     rd_id;

    assign rd_end = busy_rdata[BW-1:CW];
    assign rd_id = busy_rdata[CW-1:0];
    assign free_dec = free_depth_reg - CW'(1);
    assign free_raddr = free_dec[AW-1:0];

    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data = out_reg;

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            busy_count_reg <= '0;
            free_depth_reg <= '0;
            created_reg    <= '0;
            rd_reg         <= '0;
            wr_reg         <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            busy_count_reg <= busy_count_next;
            free_depth_reg <= free_depth_next;
            created_reg    <= created_next;
            rd_reg         <= rd_next;
            wr_reg         <= wr_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        ovf_reg <= ovf_next;
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    // Busy list memory: read at the walk pointer, write compacted or new entry
    always_ff @(posedge clk)
    begin
        if (busy_we)
        begin
            busy_mem[busy_waddr] <= busy_wdata;
        end
        busy_rdata <= busy_mem[rd_reg[AW-1:0]];
    end

    // Free stack memory: push at depth, read the top entry
    always_ff @(posedge clk)
    begin
        if (free_we)
        begin
            free_mem[free_depth_reg[AW-1:0]] <= rd_id;
        end
        free_rdata <= free_mem[free_raddr];
    end

    // Sequencer: walk, allocate, deliver
    always_comb
    begin
        state_next      = state_reg;
        busy_count_next = busy_count_reg;
        free_depth_next = free_depth_reg;
        created_next    = created_reg;
        rd_next         = rd_reg;
        wr_next         = wr_reg;
        pend_next       = pend_reg;
        id_next         = id_reg;
        ovf_next        = ovf_reg;
        cur_next        = cur_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        busy_we         = 1'b0;
        busy_waddr      = wr_reg[AW-1:0];
        busy_wdata      = busy_rdata;
        free_we         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                rd_next   = '0;
                wr_next   = '0;
                pend_next = 1'b0;
                if (req.valid)
                begin
                    cur_next   = req.data;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Retire the entry read last cycle
                if (pend_reg)
                begin
                    if (rd_end < cur_reg.start_time)
                    begin
                        if (free_depth_reg < MAX_C)
                        begin
                            free_we         = 1'b1;
                            free_depth_next = free_depth_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        busy_we = 1'b1;
                        wr_next = wr_reg + CW'(1);
                    end
                end
                // Advance the read pointer or close the walk
                if (rd_reg < busy_count_reg)
                begin
                    rd_next   = rd_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        busy_count_next = wr_reg;
                        state_next      = ST_ALLOC;
                    end
                end
            end
            ST_ALLOC:
            begin
                ovf_next = 1'b0;
                if (free_depth_reg != '0)
                begin
                    free_depth_next = free_dec;
                    state_next      = ST_POP;
                end
                else if (created_reg < MAX_C)
                begin
                    created_next = created_reg + CW'(1);
                    id_next      = created_reg + CW'(1);
                    state_next   = ST_DONE;
                end
                else
                begin
                    id_next    = '0;
                    ovf_next   = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_POP:
            begin
                id_next    = free_rdata;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next.assigned_id      = OUT_ID_W'(id_reg);
                    out_next.ids_in_use_total = OUT_ID_W'(created_reg);
                    out_next.overflow         = ovf_reg;
                    out_valid_next            = 1'b1;
                    if (!ovf_reg && busy_count_reg < MAX_C)
                    begin
                        busy_we         = 1'b1;
                        busy_waddr      = busy_count_reg[AW-1:0];
                        busy_wdata      = {cur_reg.end_time, id_reg};
                        busy_count_next = busy_count_reg + CW'(1);
                    end
                    // Drop all state at the end of a batch
                    if (cur_reg.last_request)
                    begin
                        busy_count_next = '0;
                        free_depth_next = '0;
                        created_next    = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Busy and free ids together never outnumber the created ids while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (busy_count_reg + free_depth_reg <= created_reg))
        else $error("ids lost or duplicated");

    // Overflow results carry no id
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.overflow |-> (out_reg.assigned_id == '0))
        else $error("overflow with id");

    // Overflow whenever the counter is exhausted and the stack empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ALLOC) && (free_depth_reg == '0) && (created_reg == MAX_C)
        |=> ovf_reg)
        else $error("missed overflow");

    // The walk never reads past the busy list
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (wr_reg <= rd_reg) && (rd_reg <= busy_count_reg))
        else $error("walk pointers out of range");

endmodule
`default_nettype wire

[dv/interval_resource_allocator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_resource_allocator_tb - allocator testbench
// Drives interval requests with random gaps and back-pressure, predicts each
// id, created total and overflow flag, and checks results in order.
// ----------------------------------------------------------------------------
module interval_resource_allocator_tb;
    import ira_pkg::*;

    localparam int NUM_IDS = 256;
    localparam int NUM_RANDOM = 600;
    localparam int CYCLE_LIMIT = 2000000;

    logic clk;
    logic rst_n;

    ira_req_if req_ch ();
    ira_rsp_if rsp_ch ();

    interval_resource_allocator #(.MAX_IDS(NUM_IDS)) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    // allocator shadow state
    logic [31:0] pend_end [NUM_IDS];
    logic [8:0]  pend_id [NUM_IDS];
    int          pend_count;
    logic [8:0]  spare_ids [NUM_IDS];
    int          spare_depth;
    int          made_count;

    ira_rsp_t    alloc_q[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    bit          hold_rsp;
    bit          stim_done;

    // directed table: check_row marks rows with a typed-in result
    typedef struct {
        ira_req_t rq;
        bit       check_row;
        ira_rsp_t rs;
    } dir_row_t;

    function automatic ira_rsp_t predict_alloc(input ira_req_t rq);
        ira_rsp_t r;
        int       wr;
        logic [8:0] id;
        bit       ovf;
        wr = 0;
        id = '0;
        ovf = 1'b0;
        // release expired entries, oldest first
        for (int rd = 0; rd < pend_count; rd++)
        begin
            if (pend_end[rd] < rq.start_time)
            begin
                spare_ids[spare_depth] = pend_id[rd];
                spare_depth++;
            end
            else
            begin
                pend_end[wr] = pend_end[rd];
                pend_id[wr] = pend_id[rd];
                wr++;
            end
        end
        pend_count = wr;
        if (spare_depth > 0)
        begin
            spare_depth--;
            id = spare_ids[spare_depth];
        end
        else if (made_count < NUM_IDS)
        begin
            made_count++;
            id = 9'(made_count);
        end
        else
            ovf = 1'b1;
        if (!ovf)
        begin
            pend_end[pend_count] = rq.end_time;
            pend_id[pend_count] = id;
            pend_count++;
        end
        r.assigned_id = id;
        r.ids_in_use_total = 9'(made_count);
        r.overflow = ovf;
        if (rq.last_request)
        begin
            pend_count = 0;
            spare_depth = 0;
            made_count = 0;
        end
        return r;
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("interval_resource_allocator test failed");
            $finish;
        end
    end

    // check results at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (alloc_q.size() == 0)
            begin
                $error("unexpected result id=%0d", rsp_ch.data.assigned_id);
                fail_count++;
            end
            else
            begin
                ira_rsp_t e;
                e = alloc_q.pop_front();
                if (rsp_ch.data.assigned_id !== e.assigned_id)
                begin
                    $error("assigned_id exp %0d got %0d", e.assigned_id,
                           rsp_ch.data.assigned_id);
                    fail_count++;
                end
                if (rsp_ch.data.ids_in_use_total !== e.ids_in_use_total)
                begin
                    $error("ids_in_use_total exp %0d got %0d", e.ids_in_use_total,
                           rsp_ch.data.ids_in_use_total);
                    fail_count++;
                end
                if (rsp_ch.data.overflow !== e.overflow)
                begin
                    $error("overflow exp %0d got %0d", e.overflow, rsp_ch.data.overflow);
                    fail_count++;
                end
            end
        end
    end

    // result ready: random stalls, or a long hold when asked
    initial
    begin
        int n;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_rsp)
            begin
                rsp_ch.ready <= 1'b0;
                for (int i = 0; i < 400; i++) @(negedge clk);
                hold_rsp = 1'b0;
            end
            else if (!stim_done && $urandom_range(0, 9) < 3)
            begin
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 3);
                rsp_ch.ready <= 1'b0;
                for (int i = 1; i < n; i++) @(negedge clk);
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // offer one request; valid stays high afterwards until the next request
    // or a pause replaces it, the block being busy by then
    task automatic send_request(input ira_req_t rq);
        int n;
        // random gap before the request
        if ($urandom_range(0, 9) < 3)
        begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                            : $urandom_range(1, 3);
            req_ch.valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= rq;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        alloc_q.insert(alloc_q.size(), predict_alloc(rq));
        @(negedge clk);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (alloc_q.size() != 0) @(negedge clk);
    endtask

    function automatic ira_req_t mk_req(input logic [31:0] s, input logic [31:0] e,
                                        input logic l);
        ira_req_t r;
        r.start_time = s;
        r.end_time = e;
        r.last_request = l;
        return r;
    endfunction

    function automatic ira_rsp_t mk_rsp(input int id, input int tot, input bit ovf);
        ira_rsp_t r;
        r.assigned_id = 9'(id);
        r.ids_in_use_total = 9'(tot);
        r.overflow = ovf;
        return r;
    endfunction

    // stimulus
    initial
    begin
        dir_row_t dir_tab[$];
        ira_rsp_t got;
        ira_req_t rq;
        logic [31:0] t_base;
        int      seq_len;
        int      sent;
        hold_rsp = 1'b0;
        stim_done = 1'b0;
        pend_count = 0;
        spare_depth = 0;
        made_count = 0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed rows: first id after reset, extremes, equal times, reversed
        dir_tab.insert(dir_tab.size(),
                       '{mk_req(32'd0, 32'd0, 1'b0), 1'b1, mk_rsp(1, 1, 1'b0)});
        dir_tab.insert(dir_tab.size(),
                       '{mk_req(32'd0, 32'hFFFFFFFF, 1'b0), 1'b1, mk_rsp(2, 2, 1'b0)});
        dir_tab.insert(dir_tab.size(),
                       '{mk_req(32'd1, 32'd5, 1'b0), 1'b1, mk_rsp(1, 2, 1'b0)});
        dir_tab.insert(dir_tab.size(),
                       '{mk_req(32'd5, 32'd3, 1'b0), 1'b0, mk_rsp(0, 0, 1'b0)});
        dir_tab.insert(dir_tab.size(),
                       '{mk_req(32'd4, 32'd9, 1'b0), 1'b0, mk_rsp(0, 0, 1'b0)});
        dir_tab.insert(dir_tab.size(),
                       '{mk_req(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0), 1'b0,
                         mk_rsp(0, 0, 1'b0)});
        dir_tab.insert(dir_tab.size(),
                       '{mk_req(32'hAAAAAAAA, 32'h55555555, 1'b1), 1'b0,
                         mk_rsp(0, 0, 1'b0)});
        dir_tab.insert(dir_tab.size(),
                       '{mk_req(32'h55555555, 32'hAAAAAAAA, 1'b1), 1'b1,
                         mk_rsp(1, 1, 1'b0)});
        foreach (dir_tab[i])
        begin
            send_request(dir_tab[i].rq);
            if (dir_tab[i].check_row)
            begin
                got = alloc_q[$];
                if (got !== dir_tab[i].rs)
                begin
                    $error("directed row %0d exp %h got %h", i, dir_tab[i].rs, got);
                    fail_count++;
                end
            end
        end

        // exhaust every id: overlapping intervals, then overflow
        for (int i = 0; i < NUM_IDS + 3; i++)
            send_request(mk_req(32'd10, 32'd100, 1'b0));
        // free them all at once, then close the batch
        send_request(mk_req(32'd1000, 32'd1001, 1'b1));

        // long result hold while requests keep coming
        hold_rsp = 1'b1;
        for (int i = 0; i < 8; i++)
            send_request(mk_req(32'(i), 32'(i + 2), 1'b0));
        drain_results();
        // sender pause after all results are in
        repeat (20) @(negedge clk);

        // random batches of increasing windows, with some noise
        sent = 0;
        while (sent < NUM_RANDOM)
        begin
            seq_len = $urandom_range(1, 60);
            t_base = $urandom_range(0, 1000);
            for (int k = 0; k < seq_len; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    rq = mk_req($urandom, $urandom, 1'b0);
                else
                begin
                    t_base = t_base + $urandom_range(0, 6);
                    rq = mk_req(t_base, t_base + $urandom_range(0, 30), 1'b0);
                    if ($urandom_range(0, 15) == 0)
                        rq.end_time = t_base - $urandom_range(0, 4);
                end
                rq.last_request = (k == seq_len - 1) ? ($urandom_range(0, 3) != 0)
                                                    : 1'b0;
                send_request(rq);
                sent++;
            end
        end
        stim_done = 1'b1;

        drain_results();
        repeat (300) @(negedge clk);
        if (fail_count == 0 && alloc_q.size() == 0)
            $display("interval_resource_allocator test passed");
        else
            $display("interval_resource_allocator test failed");
        $finish;
    end
endmodule

[interval_resource_allocator.f]
rtl/ira_pkg.sv
rtl/ira_req_if.sv
rtl/ira_rsp_if.sv
rtl/interval_resource_allocator.sv
dv/interval_resource_allocator_tb.sv
